[src/assert_macros.svh]
// Assertion helpers used by shamh_core.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// The condition must never be true.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

[src/shamh_pkg.sv]
package shamh_pkg;

    // One queued message transaction.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } item_t;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Fill level at which the length field starts.
    localparam logic [5:0] LEN_POS = 6'd56;

    // Fill level of the last byte of a block.
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Upper-case sigma 0, applied to working word a.
    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Upper-case sigma 1, applied to working word e.
    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Lower-case sigma 0 of the message schedule.
    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Lower-case sigma 1 of the message schedule.
    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

[src/shamh_front.sv]
module shamh_front
    import shamh_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_message,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    item_t          slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           accept;
    logic           push;
    logic           pop;

    // A transaction with neither a byte nor an end marker does nothing, so it is dropped here.
    assign msg_ready = (cnt_reg != CW'(DEPTH));
    assign accept    = msg_valid && msg_ready;
    assign push      = accept && (has_byte || end_of_message);

    assign q_valid = (cnt_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign pop     = q_valid && q_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{data: data_byte, has_byte: has_byte,
                                      eom: end_of_message};
        end
    end

endmodule

[src/shamh_core.sv]
`include "assert_macros.svh"

module shamh_core
    import shamh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    output logic  q_ready,
    input  item_t q_item,
    output logic  digest_valid,
    input  logic  digest_ready,
    output word_t digest_words [8]
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAD80  = 3'd1;
    localparam logic [2:0] S_PADZ   = 3'd2;
    localparam logic [2:0] S_PADLEN = 3'd3;
    localparam logic [2:0] S_ROUND  = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [2:0]         ret_reg;
    logic [2:0]         ret_next;
    logic [5:0]         fill_reg;
    logic [5:0]         fill_next;
    logic [2:0]         len_idx_reg;
    logic [2:0]         len_idx_next;
    logic [5:0]         rnd_reg;
    logic [5:0]         rnd_next;
    logic [63:0]        bitlen_reg;
    logic [63:0]        bitlen_next;
    word_t              chain_reg [8];
    word_t              chain_next [8];
    word_t              v_reg [8];
    word_t              v_round [8];
    logic [15:0][31:0]  blk_reg;
    logic [15:0][31:0]  blk_next;
    logic [511:0]       blk_shifted;
    logic               dv_reg;
    logic               dv_next;
    logic               load_out;
    word_t              dig_reg [8];
    logic               push_en;
    logic [7:0]         push_val;
    logic [7:0]         len_byte;
    word_t              w_cur;
    word_t              w_new;
    word_t              t1;
    word_t              t2;

    assign digest_valid = dv_reg;
    assign digest_words = dig_reg;

    // Length bytes go out most significant first.
    assign len_byte = bitlen_reg[{~len_idx_reg, 3'b000} +: 8];

    // Block buffer: bytes shift in at the bottom, word 0 ends at the top.
    assign blk_shifted = {blk_reg[15][23:0], blk_reg[14:0], push_val};

    // Message schedule: the top word is W[t], the new word is W[t+16].
    assign w_cur = blk_reg[15];
    assign w_new = blk_reg[15] + small_sigma0(blk_reg[14]) + blk_reg[6]
                 + small_sigma1(blk_reg[1]);

    // One compression round.
    always_comb
    begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[rnd_reg] + w_cur;
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_round[0] = t1 + t2;
        v_round[1] = v_reg[0];
        v_round[2] = v_reg[1];
        v_round[3] = v_reg[2];
        v_round[4] = v_reg[3] + t1;
        v_round[5] = v_reg[4];
        v_round[6] = v_reg[5];
        v_round[7] = v_reg[6];
    end

    // Sequencer: buffering, padding, rounds, chaining update and digest hand-off.
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        len_idx_next = len_idx_reg;
        rnd_next     = rnd_reg;
        bitlen_next  = bitlen_reg;
        chain_next   = chain_reg;
        dv_next      = dv_reg && !digest_ready;
        load_out     = 1'b0;
        push_en      = 1'b0;
        push_val     = 8'h00;
        q_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (q_item.has_byte)
                    begin
                        push_en     = 1'b1;
                        push_val    = q_item.data;
                        bitlen_next = bitlen_reg + 64'd8;
                    end
                    if (q_item.has_byte && fill_reg == LAST_POS)
                    begin
                        state_next = S_ROUND;
                        ret_next   = q_item.eom ? S_PAD80 : S_IDLE;
                    end
                    else if (q_item.eom)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                push_en    = 1'b1;
                push_val   = PAD_BYTE;
                state_next = S_PADZ;
                if (fill_reg == LAST_POS)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_PADZ;
                end
            end
            S_PADZ:
            begin
                if (fill_reg == LEN_POS)
                begin
                    state_next = S_PADLEN;
                end
                else
                begin
                    push_en = 1'b1;
                    if (fill_reg == LAST_POS)
                    begin
                        state_next = S_ROUND;
                        ret_next   = S_PADZ;
                    end
                end
            end
            S_PADLEN:
            begin
                push_en      = 1'b1;
                push_val     = len_byte;
                len_idx_next = len_idx_reg + 1'b1;
                if (fill_reg == LAST_POS)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_OUT;
                end
            end
            S_ROUND:
            begin
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (!dv_reg || digest_ready)
                begin
                    load_out    = 1'b1;
                    dv_next     = 1'b1;
                    chain_next  = INIT_HASH;
                    bitlen_next = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign fill_next = push_en ? fill_reg + 1'b1 : fill_reg;

    // The buffer also serves as the sliding schedule window during the rounds.
    always_comb
    begin
        if (push_en)
        begin
            blk_next = blk_shifted;
        end
        else if (state_reg == S_ROUND)
        begin
            blk_next = {blk_reg[14:0], w_new};
        end
        else
        begin
            blk_next = blk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            fill_reg    <= '0;
            len_idx_reg <= '0;
            rnd_reg     <= '0;
            bitlen_reg  <= '0;
            chain_reg   <= INIT_HASH;
            dv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            fill_reg    <= fill_next;
            len_idx_reg <= len_idx_next;
            rnd_reg     <= rnd_next;
            bitlen_reg  <= bitlen_next;
            chain_reg   <= chain_next;
            dv_reg      <= dv_next;
        end
    end

    // Working variables follow the chaining words until the rounds start.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (state_reg == S_ROUND)
        begin
            v_reg <= v_round;
        end
        else
        begin
            v_reg <= chain_reg;
        end
        if (load_out)
        begin
            dig_reg <= chain_reg;
        end
    end

    `ASSERT_CLK(a_rnd_idle, (state_reg != S_ROUND) |-> (rnd_reg == 6'd0))
    `ASSERT_CLK(a_rnd_end, (state_reg == S_ROUND && rnd_reg == LAST_ROUND) |=> (state_reg == S_FINAL))
    `ASSERT_CLK(a_len_start, (state_reg == S_PADLEN && len_idx_reg == 3'd0) |-> (fill_reg == LEN_POS))
    `ASSERT_CLK(a_out_src, $rose(dv_reg) |-> ($past(state_reg) == S_OUT))

endmodule

[src/sha256_message_hasher.sv]
// SHA-256 hasher for a byte-serial message.
// Input channel (msg_valid/msg_ready): each transaction carries data_byte when
// has_byte is high; end_of_message closes the message after that byte, if any.
// A transaction with both flags low is taken and ignored.
// Output channel (digest_valid/digest_ready): one transaction per message with
// the eight digest words, word 0 holding digest bytes 0 to 3, big-endian.
// A queue of QUEUE_DEPTH transactions sits in front of the hash engine, so the
// source can keep sending while a block is being compressed, until the queue is full.
// The engine takes in bytes one at a time; after every full 64-byte block it
// runs 64 rounds, one per cycle, then the chaining update, taking no bytes.
// The end of a message takes padding plus one or two block compressions.
// While a digest waits for digest_ready, the engine goes on with the next
// message and holds its digest once done; the queue keeps accepting bytes
// until it is full.
// Reset clears the queue, the length and the fill level and loads the initial
// hash values; the engine comes out of reset idle and ready for a message.
module sha256_message_hasher
    import shamh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word_0,
    output logic [31:0] digest_word_1,
    output logic [31:0] digest_word_2,
    output logic [31:0] digest_word_3,
    output logic [31:0] digest_word_4,
    output logic [31:0] digest_word_5,
    output logic [31:0] digest_word_6,
    output logic [31:0] digest_word_7
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;
    word_t digest_words [8];

    // Front end: accepts transactions and queues the meaningful ones.
    shamh_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_ready      (msg_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item)
    );

    // Back end: buffering, padding, compression and digest register.
    shamh_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_words (digest_words)
    );

    assign digest_word_0 = digest_words[0];
    assign digest_word_1 = digest_words[1];
    assign digest_word_2 = digest_words[2];
    assign digest_word_3 = digest_words[3];
    assign digest_word_4 = digest_words[4];
    assign digest_word_5 = digest_words[5];
    assign digest_word_6 = digest_words[6];
    assign digest_word_7 = digest_words[7];

endmodule
